// ===== design/srps_pkg.sv =====
// Shared constants, queue entry type and SECDED encoder for the pulse serializer.
package srps_pkg;

  localparam int unsigned WORD_W       = 16;
  localparam int unsigned SAMPLE_W     = 7;
  localparam int unsigned TICK_W       = 16;
  localparam int unsigned COUNT_W      = 4;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [WORD_W-1:0] PREAMBLE = 16'hF000;

  localparam logic [TICK_W-1:0]  BIT_TIME_RESET     = 16'd84;
  localparam logic [TICK_W-1:0]  PACKET_GAP_RESET   = 16'd84;
  localparam logic [TICK_W-1:0]  LEAD_GAP_RESET     = 16'd10;
  localparam logic [COUNT_W-1:0] PACKET_COUNT_RESET = 4'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_BIT_TIME     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PACKET_GAP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEAD_GAP     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PACKET_COUNT = 2'd3;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] code_word;
  } srps_entry_t;

  // Preamble, seven data bits, four Hamming check bits, overall parity last.
  function automatic logic [WORD_W-1:0] srps_encode(input logic [SAMPLE_W-1:0] s);
    logic [WORD_W-1:0] w;
    logic c4;
    logic c3;
    logic c2;
    logic c1;
    logic c0;
    w  = PREAMBLE | {4'b0000, s, 5'b00000};
    c4 = w[11] ^ w[10] ^ w[9];
    c3 = w[8] ^ w[7] ^ w[6];
    c2 = w[11] ^ w[10] ^ w[8] ^ w[7] ^ w[5];
    c1 = w[11] ^ w[9] ^ w[8] ^ w[6] ^ w[5];
    c0 = (^w[11:5]) ^ c4 ^ c3 ^ c2 ^ c1;
    return {w[15:5], c4, c3, c2, c1, c0};
  endfunction

endpackage

// ===== design/srps_front.sv =====
// Front end: accepts input transactions, classifies them and encodes start samples.
module srps_front (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [srps_pkg::SAMPLE_W-1:0]  sample,
  output logic                           push_valid,
  input  logic                           push_ready,
  output srps_pkg::srps_entry_t          push_entry
);
  import srps_pkg::*;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_entry.start     = operation;
    // tick transactions carry no word
    push_entry.code_word = operation ? srps_encode(sample) : '0;
  end

endmodule

// ===== design/srps_queue.sv =====
// Small FIFO that decouples the front end from the pulse engine.
module srps_queue #(
  parameter int unsigned DEPTH = srps_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  srps_pkg::srps_entry_t push_entry,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output srps_pkg::srps_entry_t pop_entry
);
  import srps_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  srps_entry_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/srps_back.sv =====
// Pulse engine: configuration registers, phase sequencer and output register.
module srps_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [srps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             pop_valid,
  output logic                             pop_ready,
  input  srps_pkg::srps_entry_t            pop_entry,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             radio_level,
  output logic                             busy_res,
  output logic                             last_tick,
  output logic                             start_refused
);
  import srps_pkg::*;

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_BIT  = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_GAP  = 2'd3;

  localparam logic [POS_W-1:0] POS_FIRST = '1;

  logic [TICK_W-1:0]  bit_time;
  logic [TICK_W-1:0]  packet_gap;
  logic [TICK_W-1:0]  lead_gap;
  logic [COUNT_W-1:0] packet_count;

  logic [WORD_W-1:0]  code_word,    code_word_next;
  logic [POS_W-1:0]   bit_position, bit_position_next;
  logic [COUNT_W-1:0] packets_sent, packets_sent_next;
  logic [1:0]         phase,        phase_next;
  logic [TICK_W-1:0]  phase_ticks,  phase_ticks_next;
  logic               active,       active_next;

  logic [TICK_W-1:0]  bt_eff;
  logic [COUNT_W-1:0] cnt_eff;
  logic [TICK_W-1:0]  cur_len;
  logic [TICK_W-1:0]  ticks_inc;
  logic [COUNT_W-1:0] sent_inc;
  logic [1:0]         restart_phase;
  logic               pop;
  logic               res_level;
  logic               res_busy;
  logic               res_last;
  logic               res_refused;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time     <= BIT_TIME_RESET;
      packet_gap   <= PACKET_GAP_RESET;
      lead_gap     <= LEAD_GAP_RESET;
      packet_count <= PACKET_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIT_TIME:     bit_time     <= cfg_data;
        REG_PACKET_GAP:   packet_gap   <= cfg_data;
        REG_LEAD_GAP:     lead_gap     <= cfg_data;
        REG_PACKET_COUNT: packet_count <= cfg_data[COUNT_W-1:0];
      endcase
    end
  end

  assign bt_eff        = (bit_time == '0) ? TICK_W'(1) : bit_time;
  assign cnt_eff       = (packet_count == '0) ? COUNT_W'(1) : packet_count;
  assign restart_phase = (lead_gap == '0) ? PH_BIT : PH_LEAD;
  assign ticks_inc     = phase_ticks + 1'b1;
  assign sent_inc      = packets_sent + 1'b1;

  always_comb begin
    unique case (phase)
      PH_LEAD: cur_len = lead_gap;
      PH_BIT:  cur_len = bt_eff;
      PH_LOW:  cur_len = bt_eff;
      PH_GAP:  cur_len = packet_gap;
    endcase
  end

  // Advance when the output slot is free or being drained.
  assign pop_ready = !out_valid || out_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    code_word_next    = code_word;
    bit_position_next = bit_position;
    packets_sent_next = packets_sent;
    phase_next        = phase;
    phase_ticks_next  = phase_ticks;
    active_next       = active;
    res_level         = 1'b0;
    res_busy          = 1'b0;
    res_last          = 1'b0;
    res_refused       = 1'b0;
    if (pop) begin
      if (pop_entry.start) begin
        res_busy = 1'b1;
        if (active) begin
          res_refused = 1'b1;
        end else begin
          code_word_next    = pop_entry.code_word;
          bit_position_next = POS_FIRST;
          packets_sent_next = '0;
          phase_next        = restart_phase;
          phase_ticks_next  = '0;
          active_next       = 1'b1;
        end
      end else if (active) begin
        res_busy = 1'b1;
        if (phase == PH_BIT) begin
          res_level = code_word[bit_position];
        end
        phase_ticks_next = ticks_inc;
        if (ticks_inc == '0 || ticks_inc >= cur_len) begin
          phase_ticks_next = '0;
          // Fold in the follow-on phases that have zero length.
          unique case (phase)
            PH_LEAD: phase_next = PH_BIT;
            PH_BIT:  phase_next = PH_LOW;
            PH_LOW: begin
              if (bit_position != '0) begin
                bit_position_next = bit_position - 1'b1;
                phase_next        = restart_phase;
              end else if (packet_gap != '0) begin
                phase_next = PH_GAP;
              end else begin
                packets_sent_next = sent_inc;
                bit_position_next = POS_FIRST;
                if (sent_inc >= cnt_eff) begin
                  active_next = 1'b0;
                  phase_next  = PH_LEAD;
                  res_last    = 1'b1;
                end else begin
                  phase_next = restart_phase;
                end
              end
            end
            PH_GAP: begin
              packets_sent_next = sent_inc;
              bit_position_next = POS_FIRST;
              if (sent_inc >= cnt_eff) begin
                active_next = 1'b0;
                phase_next  = PH_LEAD;
                res_last    = 1'b1;
              end else begin
                phase_next = restart_phase;
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_word    <= '0;
      bit_position <= POS_FIRST;
      packets_sent <= '0;
      phase        <= PH_LEAD;
      phase_ticks  <= '0;
      active       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      code_word    <= code_word_next;
      bit_position <= bit_position_next;
      packets_sent <= packets_sent_next;
      phase        <= phase_next;
      phase_ticks  <= phase_ticks_next;
      active       <= active_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      radio_level   <= res_level;
      busy_res      <= res_busy;
      last_tick     <= res_last;
      start_refused <= res_refused;
    end
  end

endmodule

// ===== design/secded_radio_pulse_serializer.sv =====
// Top level of the SECDED radio pulse serializer.
// One input transaction gives one result transaction. A start transaction encodes a
// 7-bit sample into a 16-bit word (four preamble ones, the data, four Hamming check
// bits, overall parity) and a tick transaction drives one line level. The front end
// encodes into a QUEUE_DEPTH-entry queue; the pulse engine takes one entry per clock
// cycle into its output register while that is empty or drained, so a new item can be
// taken every cycle unless the receiver stalls and the sustained rate is one item per
// cycle, set by the engine's phase step. Each input is registered in the queue, then
// in the output register. Write configuration only while the block is idle.
module secded_radio_pulse_serializer #(
  parameter int unsigned QUEUE_DEPTH = srps_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [srps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic [srps_pkg::SAMPLE_W-1:0]    sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             radio_level,
  output logic                             busy_res,
  output logic                             last_tick,
  output logic                             start_refused
);
  import srps_pkg::*;

  logic        push_valid;
  logic        push_ready;
  srps_entry_t push_entry;
  logic        pop_valid;
  logic        pop_ready;
  srps_entry_t pop_entry;

  srps_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .sample     (sample),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  srps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  srps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_entry     (pop_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .radio_level   (radio_level),
    .busy_res      (busy_res),
    .last_tick     (last_tick),
    .start_refused (start_refused)
  );

endmodule

// ===== sim/srps_tb_pkg.sv =====
// Transaction codes shared by the pulse serializer testbench files.
`timescale 1ns / 1ps
package srps_tb_pkg;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } srps_op_e;

endpackage

// ===== sim/srps_pulse_checker.sv =====
// Watches the serializer ports, predicts every line level and compares the results.
`timescale 1ns / 1ps
module srps_pulse_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [srps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [srps_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             operation,
  input  logic [srps_pkg::SAMPLE_W-1:0]    sample,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             radio_level,
  input  logic                             busy_res,
  input  logic                             last_tick,
  input  logic                             start_refused,
  output int                               errors,
  output int                               pending
);
  import srps_tb_pkg::*;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_HIGH   = 2'd1,
    PH_LOW    = 2'd2,
    PH_PKTGAP = 2'd3
  } pulse_phase_e;

  typedef struct packed {
    logic level;
    logic busy;
    logic last;
    logic refused;
  } pulse_result_t;

  // shadow copies of the configuration registers
  logic [15:0] bit_time_q;
  logic [15:0] packet_gap_q;
  logic [15:0] lead_gap_q;
  logic [3:0]  packet_count_q;

  // predicted engine state
  logic [15:0]  word_q;
  logic [3:0]   bit_pos_q;
  logic [3:0]   packets_q;
  pulse_phase_e phase_q;
  logic [15:0]  ticks_q;
  logic         sending_q;

  pulse_result_t pending_pulses[$];
  int            mismatches = 0;

  assign errors = mismatches;

  function automatic logic [15:0] hamming_word(input logic [6:0] d);
    logic c4;
    logic c3;
    logic c2;
    logic c1;
    logic c0;
    c4 = d[6] ^ d[5] ^ d[4];
    c3 = d[3] ^ d[2] ^ d[1];
    c2 = d[6] ^ d[5] ^ d[3] ^ d[2] ^ d[0];
    c1 = d[6] ^ d[4] ^ d[3] ^ d[1] ^ d[0];
    c0 = (^d) ^ c4 ^ c3 ^ c2 ^ c1;
    return srps_pkg::PREAMBLE | {4'b0000, d, c4, c3, c2, c1, c0};
  endfunction

  function automatic logic [15:0] span_of(input pulse_phase_e p);
    case (p)
      PH_LEAD:         return lead_gap_q;
      PH_HIGH, PH_LOW: return (bit_time_q == 16'd0) ? 16'd1 : bit_time_q;
      default:         return packet_gap_q;
    endcase
  endfunction

  task automatic step_phase(output logic done);
    logic [3:0] reps;
    reps = (packet_count_q == 4'd0) ? 4'd1 : packet_count_q;
    done = 1'b0;
    ticks_q = 16'd0;
    case (phase_q)
      PH_LEAD: phase_q = PH_HIGH;
      PH_HIGH: phase_q = PH_LOW;
      PH_LOW: begin
        if (bit_pos_q == 4'd0) begin
          phase_q = PH_PKTGAP;
        end else begin
          bit_pos_q = bit_pos_q - 4'd1;
          phase_q = PH_LEAD;
        end
      end
      default: begin
        packets_q = packets_q + 4'd1;
        bit_pos_q = 4'd15;
        phase_q = PH_LEAD;
        if (packets_q >= reps) begin
          sending_q = 1'b0;
          done = 1'b1;
        end
      end
    endcase
  endtask

  // step once, then skip over phases whose length is zero
  task automatic move_on(output logic done);
    step_phase(done);
    while (!done && span_of(phase_q) == 16'd0)
      step_phase(done);
  endtask

  task automatic predict_pulse(input srps_op_e op, input logic [6:0] smp,
                               output pulse_result_t r);
    logic done;
    r = '0;
    if (op == OP_START) begin
      if (sending_q) begin
        r.refused = 1'b1;
      end else begin
        word_q = hamming_word(smp);
        bit_pos_q = 4'd15;
        packets_q = 4'd0;
        phase_q = (lead_gap_q == 16'd0) ? PH_HIGH : PH_LEAD;
        ticks_q = 16'd0;
        sending_q = 1'b1;
      end
      r.busy = 1'b1;
    end else if (sending_q) begin
      r.busy = 1'b1;
      if (phase_q == PH_HIGH)
        r.level = word_q[bit_pos_q];
      ticks_q = ticks_q + 16'd1;
      if (ticks_q >= span_of(phase_q) || ticks_q == 16'd0) begin
        move_on(done);
        r.last = done;
      end
    end
  endtask

  task automatic note_mismatch(input string what, input pulse_result_t want,
                               input pulse_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: level %b/%b busy %b/%b last %b/%b refused %b/%b (exp/act)",
               $time, what, want.level, got.level, want.busy, got.busy,
               want.last, got.last, want.refused, got.refused);
  endtask

  always @(posedge clk) begin : watch
    pulse_result_t got;
    pulse_result_t want;
    if (rst) begin
      bit_time_q     = srps_pkg::BIT_TIME_RESET;
      packet_gap_q   = srps_pkg::PACKET_GAP_RESET;
      lead_gap_q     = srps_pkg::LEAD_GAP_RESET;
      packet_count_q = srps_pkg::PACKET_COUNT_RESET;
      word_q    = 16'd0;
      bit_pos_q = 4'd15;
      packets_q = 4'd0;
      phase_q   = PH_LEAD;
      ticks_q   = 16'd0;
      sending_q = 1'b0;
      pending_pulses.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {radio_level, busy_res, last_tick, start_refused};
        if (pending_pulses.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = pending_pulses.pop_front();
          if (got !== want)
            note_mismatch("wrong result", want, got);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          srps_pkg::REG_BIT_TIME:     bit_time_q = cfg_data;
          srps_pkg::REG_PACKET_GAP:   packet_gap_q = cfg_data;
          srps_pkg::REG_LEAD_GAP:     lead_gap_q = cfg_data;
          srps_pkg::REG_PACKET_COUNT: packet_count_q = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_pulse(srps_op_e'(operation), sample, want);
        pending_pulses.push_back(want);
      end
    end
    pending = pending_pulses.size();
  end

endmodule

// ===== sim/secded_radio_pulse_serializer_test.sv =====
// Stimulus, clock, reset and verdict for the SECDED radio pulse serializer.
`timescale 1ns / 1ps
module secded_radio_pulse_serializer_test;
  import srps_tb_pkg::*;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_we = 1'b0;
  logic [srps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [srps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             operation = 1'b0;
  logic [srps_pkg::SAMPLE_W-1:0]    sample = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             radio_level;
  logic                             busy_res;
  logic                             last_tick;
  logic                             start_refused;
  int                               errors;
  int                               pending;

  int items_accepted = 0;
  bit steady = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  always #2 clk = ~clk;

  secded_radio_pulse_serializer dut (.*);

  srps_pulse_checker checker_i (.*);

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls, one long hold-off so the input side backs up.
  initial begin : receiver
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (500) @(posedge clk);
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b0;
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_item(input srps_op_e op, input logic [6:0] smp);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55)
      gap = 0;
    else if (r < 90)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_accepted++;
    if (items_accepted >= 700)
      hold_request = 1'b1;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(OP_TICK, 7'($urandom_range(0, 127)));
  endtask

  // Drain every outstanding transaction before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [srps_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [srps_pkg::CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One sample: a start, then enough ticks to finish it, with occasional
  // refused starts, idle ticks ahead of it or an early cut.
  task automatic send_sample(input int bt, input int pg, input int lg, input int pc);
    int dur;
    int cut;
    dur = ((pc == 0) ? 1 : pc) * (16 * (lg + 2 * ((bt == 0) ? 1 : bt)) + pg);
    steady = ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 9) == 0)
      send_ticks($urandom_range(1, 4));
    send_item(OP_START, 7'($urandom_range(0, 127)));
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, dur) : dur + $urandom_range(0, 2);
    for (int i = 0; i < cut; i++) begin
      if ($urandom_range(0, 29) == 0)
        send_item(OP_START, 7'($urandom_range(0, 127)));
      send_item(OP_TICK, 7'($urandom_range(0, 127)));
    end
  endtask

  task automatic run_setting(input int bt, input int pg, input int lg, input int pc,
                             input int n_items);
    int stop_at;
    settle();
    write_reg(srps_pkg::REG_BIT_TIME, 16'(bt));
    write_reg(srps_pkg::REG_PACKET_GAP, 16'(pg));
    write_reg(srps_pkg::REG_LEAD_GAP, 16'(lg));
    write_reg(srps_pkg::REG_PACKET_COUNT, 16'(pc));
    stop_at = items_accepted + n_items;
    while (items_accepted < stop_at)
      send_sample(bt, pg, lg, pc);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: idle tick, full-ones sample, refused start
    send_item(OP_TICK, 7'h7F);
    send_item(OP_START, 7'h7F);
    send_item(OP_START, 7'h00);
    send_ticks(4);

    // shorten the running lead gap to zero; it still takes one tick
    settle();
    write_reg(srps_pkg::REG_LEAD_GAP, 16'd0);
    send_ticks(3);

    // extremes while the bit level is held
    settle();
    write_reg(srps_pkg::REG_BIT_TIME, 16'hFFFF);
    write_reg(srps_pkg::REG_PACKET_GAP, 16'hFFFF);
    write_reg(srps_pkg::REG_PACKET_COUNT, 16'd15);
    send_ticks(4);

    // zero bit time acts as one; finish the sample in one packet
    settle();
    write_reg(srps_pkg::REG_BIT_TIME, 16'd0);
    write_reg(srps_pkg::REG_PACKET_GAP, 16'd0);
    write_reg(srps_pkg::REG_PACKET_COUNT, 16'd1);
    send_ticks(34);

    // all-zero sample under the longest lead gap
    settle();
    write_reg(srps_pkg::REG_LEAD_GAP, 16'hFFFF);
    send_item(OP_START, 7'h00);
    send_ticks(3);

    run_setting(1, 0, 0, 1, 250);
    run_setting(0, 3, 1, 0, 250);
    run_setting(2, 5, 2, 2, 300);
    run_setting(1, 0, 0, 15, 400);
    repeat (2)
      run_setting($urandom_range(1, 3), $urandom_range(0, 6), $urandom_range(0, 3),
                  $urandom_range(1, 3), 150);

    steady = 1'b0;
    settle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
